@@ rtl/vtp_pkg.sv @@
package vtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STAGES = 32 + FRAC_BITS;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;

  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] fx_t;

  typedef struct packed {
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic        neg;
    logic        do_div;
    fx_t         raw;
  } div_req_t;

endpackage

@@ rtl/vertex_transform_perspective_core.sv @@
// Transforms one homogeneous Q16.16 vertex per clock by a 4x4 matrix and applies the
// perspective divide on x, y, z when the transformed w is neither 0 nor 1.0. An accepted
// word is registered in the four row lanes (products, pair sums, final sum with shift and
// clamp), then in the input register and quotient stages of the three pipelined restoring
// dividers (one quotient bit per stage) and then in one output register. A new word is
// taken every cycle unless a result is held at the output. Reset loads the identity matrix.
module vertex_transform_perspective_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [127:0]                          s_tdata,  // in_x, in_y, in_z, in_w
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [127:0]                          m_tdata,  // out_x, out_y, out_z, out_w
  output logic [1:0]                            m_tuser,  // did_divide, saturated
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [63:0]                           cfg_data
);

  localparam int DS = vtp_pkg::DIV_STAGES;
  localparam int NV = 3 + DS + 1;

  logic [63:0]  m [vtp_pkg::NUM_REGS];
  logic         en;
  logic [NV-1:0] vld;
  vtp_pkg::fx_t vin [4];
  vtp_pkg::fx_t row_res [4];
  logic [3:0]   row_sat;
  logic         do_div;
  vtp_pkg::fx_t div_res [3];
  logic [2:0]   div_sat;
  vtp_pkg::fx_t w_d [DS+1];
  logic         rs_d [DS+1];
  logic         dd_d [DS+1];

  assign en = m_tready || !m_tvalid;
  assign s_tready = en && !rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      m[0] <= 64'd65536;
      m[1] <= '0;
      m[2] <= 64'd281474976710656;
      m[3] <= '0;
      m[4] <= '0;
      m[5] <= 64'd65536;
      m[6] <= '0;
      m[7] <= 64'd281474976710656;
    end else if (cfg_valid && cfg_index < vtp_pkg::CFG_IDX_W'(vtp_pkg::NUM_REGS)) begin
      m[cfg_index[2:0]] <= cfg_data;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_in
    assign vin[i] = s_tdata[32*i +: 32];
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    vtp_pkg::fx_t coef [4];
    for (genvar c = 0; c < 4; c++) begin : g_c
      assign coef[c] = m[2*r + c/2][32*(c%2) +: 32];
    end
    vtp_row_lane u_row (
      .clk  (clk),
      .en   (en),
      .coef (coef),
      .vin  (vin),
      .res  (row_res[r]),
      .sat  (row_sat[r])
    );
  end

  assign do_div = (row_res[3] != '0) && (row_res[3] != vtp_pkg::FX_ONE);

  for (genvar l = 0; l < 3; l++) begin : g_div
    vtp_pkg::div_req_t req;
    assign req.num_mag = row_res[l][31] ? 32'(-row_res[l]) : 32'(row_res[l]);
    assign req.den_mag = row_res[3][31] ? 32'(-row_res[3]) : 32'(row_res[3]);
    assign req.neg = row_res[l][31] ^ row_res[3][31];
    assign req.do_div = do_div;
    assign req.raw = row_res[l];
    vtp_div_lane u_div (
      .clk (clk),
      .en  (en),
      .req (req),
      .res (div_res[l]),
      .sat (div_sat[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_d[0] <= row_res[3];
      rs_d[0] <= |row_sat;
      dd_d[0] <= do_div;
      for (int k = 1; k <= DS; k++) begin
        w_d[k] <= w_d[k-1];
        rs_d[k] <= rs_d[k-1];
        dd_d[k] <= dd_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[NV-2:0], s_tvalid};
      m_tvalid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {w_d[DS], div_res[2], div_res[1], div_res[0]};
      m_tuser <= {rs_d[DS] || (|div_sat), dd_d[DS]};
    end
  end

`ifndef SYNTHESIS
  a_div_w: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[127:96] != '0 && m_tdata[127:96] != vtp_pkg::FX_ONE)
    else $error("divide flagged on w of zero or one");
  a_nodiv_w: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[127:96] == '0 || m_tdata[127:96] == vtp_pkg::FX_ONE)
    else $error("divide skipped on w other than zero or one");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vld))
    else $error("pipeline advanced while output stalled");
`endif

endmodule

@@ rtl/vtp_row_lane.sv @@
module vtp_row_lane (
  input  logic             clk,
  input  logic             en,
  input  vtp_pkg::fx_t     coef [4],
  input  vtp_pkg::fx_t     vin [4],
  output vtp_pkg::fx_t     res,
  output logic             sat
);

  logic signed [63:0] prod [4];
  logic signed [64:0] s01;
  logic signed [64:0] s23;
  logic signed [65:0] total;
  logic signed [65:0] shifted;

  assign total = 66'(s01) + 66'(s23);
  assign shifted = total >>> vtp_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= 64'(coef[c]) * 64'(vin[c]);
      end
      s01 <= 65'(prod[0]) + 65'(prod[1]);
      s23 <= 65'(prod[2]) + 65'(prod[3]);
      if (shifted > 66'(vtp_pkg::FX_MAX)) begin
        res <= vtp_pkg::FX_MAX;
        sat <= 1'b1;
      end else if (shifted < 66'(vtp_pkg::FX_MIN)) begin
        res <= vtp_pkg::FX_MIN;
        sat <= 1'b1;
      end else begin
        res <= shifted[31:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/vtp_div_lane.sv @@
module vtp_div_lane (
  input  logic              clk,
  input  logic              en,
  input  vtp_pkg::div_req_t req,
  output vtp_pkg::fx_t      res,
  output logic              sat
);

  localparam int DS = vtp_pkg::DIV_STAGES;

  logic [31:0]   rem [DS+1];
  logic [DS-1:0] dvd [DS+1];
  logic [DS-1:0] quo [DS+1];
  logic [31:0]   den [DS+1];
  logic          neg [DS+1];
  logic          dod [DS+1];
  vtp_pkg::fx_t  raw [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dvd[0] <= {req.num_mag, vtp_pkg::FRAC_BITS'(0)};
      quo[0] <= '0;
      den[0] <= req.den_mag;
      neg[0] <= req.neg;
      dod[0] <= req.do_div;
      raw[0] <= req.raw;
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_st
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem[k-1], dvd[k-1][DS-1]};
    assign diff = trial - {1'b0, den[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[32]) begin
          rem[k] <= diff[31:0];
          quo[k] <= {quo[k-1][DS-2:0], 1'b1};
        end else begin
          rem[k] <= trial[31:0];
          quo[k] <= {quo[k-1][DS-2:0], 1'b0};
        end
        dvd[k] <= {dvd[k-1][DS-2:0], 1'b0};
        den[k] <= den[k-1];
        neg[k] <= neg[k-1];
        dod[k] <= dod[k-1];
        raw[k] <= raw[k-1];
      end
    end
  end

  always_comb begin
    res = raw[DS];
    sat = 1'b0;
    if (dod[DS]) begin
      if (neg[DS]) begin
        if (quo[DS] > DS'(33'h1_0000_0000 >> 1)) begin
          res = vtp_pkg::FX_MIN;
          sat = 1'b1;
        end else begin
          res = -(quo[DS][31:0]);
        end
      end else if (quo[DS] > DS'(32'h7fff_ffff)) begin
        res = vtp_pkg::FX_MAX;
        sat = 1'b1;
      end else begin
        res = quo[DS][31:0];
      end
    end
  end

endmodule
